[rtl/rdwd_pkg.sv]
`default_nettype none
package rdwd_pkg;

	// request codes
	localparam logic [2:0] REQ_PUSH_TAIL = 3'd0;
	localparam logic [2:0] REQ_POP_HEAD  = 3'd1;
	localparam logic [2:0] REQ_POP_TAIL  = 3'd2;
	localparam logic [2:0] REQ_DELETE    = 3'd3;
	localparam logic [2:0] REQ_DROP_HALF = 3'd4;

	// result status codes
	localparam logic [1:0] ST_DONE  = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	// random pick generator
	localparam logic [15:0] LFSR_SEED = 16'hACE1;
	localparam logic [15:0] LFSR_TAPS = 16'hB400;

	localparam int FD_W  = 16;
	localparam int TAG_W = 32;
	localparam int ENT_W = FD_W + TAG_W;

	typedef enum logic [2:0] {
		S_IDLE,
		S_ISSUE,
		S_CHECK,
		S_STEP,
		S_MOD,
		S_COMPACT,
		S_EMIT
	} state_t;

	function automatic logic [15:0] lfsr_next(input logic [15:0] v);
		logic [15:0] s;
		s = v >> 1;
		return v[0] ? (s ^ LFSR_TAPS) : s;
	endfunction

endpackage
`default_nettype wire

[rtl/request_deque_with_drop_unit.sv]
`default_nettype none
// Ordered request queue of DEPTH entries (descriptor + tag), slot 0 at head.
// Input channel: in_valid/in_stall carries req_type, request_fd, request_tag.
// Output channel: out_valid/out_stall carries one beat per result; the final
// beat of a request has last set. Only one request is in work at a time;
// in_stall stays high until its last result is in the output register and storage is settled.
// Steps per request: a push writes the RAM directly; pops read the slot
// through the registered RAM read, and a pop head then runs a compaction
// sweep; a delete scans the slots from the head, compacting on a hit; a
// drop runs per pick an LFSR step, a bit-serial modulo, a read, a check
// and a result, takes a new pick on a slot already taken, then compacts.
// A stalled output beat holds its payload; the engine waits for the output
// register to free before presenting the next result.
// Reset clears the count, the LFSR (to its seed), the removal marks and all
// control state; RAM contents are not cleared and are only read below the
// count.
module request_deque_with_drop_unit #(
	parameter int DEPTH = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [2:0]  req_type,
	input  wire logic [15:0] request_fd,
	input  wire logic [31:0] request_tag,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [15:0]      result_fd,
	output logic [31:0]      result_tag,
	output logic [1:0]       status,
	output logic [4:0]       entry_count,
	output logic             queue_empty,
	output logic             last
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int NW = $clog2(DEPTH + 1);
	localparam int EW = rdwd_pkg::ENT_W;

	rdwd_pkg::state_t state_q, state_d, ret_q, ret_d;

	logic [2:0]       type_q, type_d;
	logic [15:0]      fd_q, fd_d;
	logic [NW-1:0]    held_q, held_d, n_q, n_d, done_q, done_d, tgt_q, tgt_d;
	logic [NW-1:0]    rem_q, rem_d, src_q, src_d;
	logic [15:0]      lfsr_q, lfsr_d, sh_q, sh_d;
	logic [3:0]       bc_q, bc_d;
	logic [DEPTH-1:0] mark_q, mark_d;
	logic [AW-1:0]    idx_q, idx_d, w_q, w_d, src_s1, src_d1;
	logic             valid_s1, valid_d1;
	logic [15:0]      pfd_q, pfd_d;
	logic [31:0]      ptag_q, ptag_d;
	logic [1:0]       pst_q, pst_d;
	logic             plast_q, plast_d;
	logic             load_out;

	// RAM port signals
	logic          we;
	logic [AW-1:0] waddr, raddr;
	logic [EW-1:0] wdata, rdata;

	rdwd_ram #(.WIDTH(EW), .DEPTH(DEPTH)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.raddr(raddr), .rdata(rdata)
	);

	logic [15:0]   rd_fd;
	logic [31:0]   rd_tag;
	logic [NW:0]   mod_t;
	logic [NW:0]   mod_n;
	logic [NW-1:0] idx_ext;
	logic          accept;

	assign rd_fd   = rdata[EW-1 -: 16];
	assign rd_tag  = rdata[31:0];
	assign mod_t   = {rem_q, sh_q[15]};
	assign mod_n   = {1'b0, n_q};
	assign idx_ext = NW'(idx_q);
	assign in_stall = (state_q != rdwd_pkg::S_IDLE);
	assign accept   = in_valid && !in_stall;

	// next state, datapath and RAM control
	always_comb begin
		state_d = state_q; ret_d = ret_q; type_d = type_q; fd_d = fd_q;
		held_d = held_q; n_d = n_q; done_d = done_q; tgt_d = tgt_q;
		rem_d = rem_q; src_d = src_q; lfsr_d = lfsr_q; sh_d = sh_q; bc_d = bc_q;
		mark_d = mark_q; idx_d = idx_q; w_d = w_q;
		valid_d1 = 1'b0; src_d1 = src_s1;
		pfd_d = pfd_q; ptag_d = ptag_q; pst_d = pst_q; plast_d = plast_q;
		load_out = 1'b0;
		we = 1'b0; waddr = held_q[AW-1:0];
		wdata = {request_fd, request_tag};
		raddr = idx_q;

		case (state_q)
			rdwd_pkg::S_IDLE: begin
				if (accept) begin
					type_d = req_type;
					fd_d = request_fd;
					mark_d = '0;
					pfd_d = '0; ptag_d = '0; plast_d = 1'b1;
					pst_d = rdwd_pkg::ST_EMPTY;
					ret_d = rdwd_pkg::S_IDLE;
					state_d = rdwd_pkg::S_EMIT;
					n_d = held_q;
					case (req_type)
						rdwd_pkg::REQ_PUSH_TAIL: begin
							if (held_q >= NW'(DEPTH)) begin
								pst_d = rdwd_pkg::ST_FULL;
							end else begin
								we = 1'b1;
								held_d = held_q + 1'b1;
								pst_d = rdwd_pkg::ST_DONE;
							end
						end
						rdwd_pkg::REQ_POP_HEAD, rdwd_pkg::REQ_DELETE: begin
							if (held_q != '0) begin
								idx_d = '0;
								state_d = rdwd_pkg::S_ISSUE;
							end
						end
						rdwd_pkg::REQ_POP_TAIL: begin
							if (held_q != '0) begin
								idx_d = AW'(held_q - 1'b1);
								state_d = rdwd_pkg::S_ISSUE;
							end
						end
						rdwd_pkg::REQ_DROP_HALF: begin
							if (held_q != '0) begin
								tgt_d = NW'(({1'b0, held_q} + 1'b1) >> 1);
								done_d = '0;
								state_d = rdwd_pkg::S_STEP;
							end
						end
						default: ;
					endcase
				end
			end
			rdwd_pkg::S_ISSUE: begin
				raddr = idx_q;
				state_d = rdwd_pkg::S_CHECK;
			end
			rdwd_pkg::S_CHECK: begin
				pfd_d = rd_fd; ptag_d = rd_tag;
				pst_d = rdwd_pkg::ST_DONE; plast_d = 1'b1;
				state_d = rdwd_pkg::S_EMIT;
				case (type_q)
					rdwd_pkg::REQ_POP_TAIL: begin
						held_d = held_q - 1'b1;
						ret_d = rdwd_pkg::S_IDLE;
					end
					rdwd_pkg::REQ_POP_HEAD: begin
						held_d = held_q - 1'b1;
						mark_d[idx_q] = 1'b1;
						ret_d = rdwd_pkg::S_COMPACT;
					end
					rdwd_pkg::REQ_DELETE: begin
						if (rd_fd == fd_q) begin
							held_d = held_q - 1'b1;
							mark_d[idx_q] = 1'b1;
							ret_d = rdwd_pkg::S_COMPACT;
						end else if (idx_ext + 1'b1 == held_q) begin
							pfd_d = '0; ptag_d = '0;
							pst_d = rdwd_pkg::ST_EMPTY;
							ret_d = rdwd_pkg::S_IDLE;
						end else begin
							idx_d = idx_q + 1'b1;
							state_d = rdwd_pkg::S_ISSUE;
						end
					end
					default: begin
						// drop pick
						done_d = done_q + 1'b1;
						held_d = held_q - 1'b1;
						plast_d = (done_q + 1'b1 == tgt_q);
						ret_d = (done_q + 1'b1 == tgt_q) ? rdwd_pkg::S_COMPACT
						                                   : rdwd_pkg::S_STEP;
					end
				endcase
			end
			rdwd_pkg::S_STEP: begin
				lfsr_d = rdwd_pkg::lfsr_next(lfsr_q);
				sh_d = rdwd_pkg::lfsr_next(lfsr_q);
				rem_d = '0;
				bc_d = '0;
				state_d = rdwd_pkg::S_MOD;
			end
			rdwd_pkg::S_MOD: begin
				// restoring remainder, one bit of the LFSR per cycle
				if (mod_t >= mod_n) begin
					rem_d = NW'(mod_t - mod_n);
				end else begin
					rem_d = mod_t[NW-1:0];
				end
				sh_d = {sh_q[14:0], 1'b0};
				bc_d = bc_q + 1'b1;
				if (bc_q == 4'hF) begin
					if (mark_q[rem_d[AW-1:0]]) begin
						state_d = rdwd_pkg::S_STEP;
					end else begin
						mark_d[rem_d[AW-1:0]] = 1'b1;
						idx_d = rem_d[AW-1:0];
						state_d = rdwd_pkg::S_ISSUE;
					end
				end
			end
			rdwd_pkg::S_COMPACT: begin
				// sweep: read each slot, write back kept ones in order
				raddr = src_q[AW-1:0];
				if (src_q != n_q) begin
					valid_d1 = 1'b1;
					src_d1 = src_q[AW-1:0];
					src_d = src_q + 1'b1;
				end else if (!valid_s1) begin
					state_d = rdwd_pkg::S_IDLE;
				end
				if (valid_s1 && !mark_q[src_s1]) begin
					we = 1'b1;
					waddr = w_q;
					wdata = rdata;
					w_d = w_q + 1'b1;
				end
			end
			rdwd_pkg::S_EMIT: begin
				if (!out_valid || !out_stall) begin
					load_out = 1'b1;
					state_d = ret_q;
					src_d = '0;
					w_d = '0;
				end
			end
			default: state_d = rdwd_pkg::S_IDLE;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rdwd_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ret_q    <= rdwd_pkg::S_IDLE;
			held_q   <= '0;
			lfsr_q   <= rdwd_pkg::LFSR_SEED;
			mark_q   <= '0;
			valid_s1 <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			ret_q    <= ret_d;
			held_q   <= held_d;
			lfsr_q   <= lfsr_d;
			mark_q   <= mark_d;
			valid_s1 <= valid_d1;
			if (load_out) begin
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

	logic [NW+4:0] cnt_ext;
	assign cnt_ext = (NW+5)'(held_q);

	// payload registers
	always_ff @(posedge clk) begin
		type_q <= type_d; fd_q <= fd_d; n_q <= n_d; done_q <= done_d;
		tgt_q <= tgt_d; rem_q <= rem_d; src_q <= src_d; sh_q <= sh_d;
		bc_q <= bc_d; idx_q <= idx_d; w_q <= w_d; src_s1 <= src_d1;
		pfd_q <= pfd_d; ptag_q <= ptag_d; pst_q <= pst_d; plast_q <= plast_d;
		if (load_out) begin
			result_fd   <= pfd_q;
			result_tag  <= ptag_q;
			status      <= pst_q;
			entry_count <= cnt_ext[4:0];
			queue_empty <= (held_q == '0);
			last        <= plast_q;
		end
	end
endmodule
`default_nettype wire

[rtl/rdwd_ram.sv]
`default_nettype none
// simple dual port RAM, one write, one registered read
module rdwd_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

[sim/tb_request_deque_with_drop_unit.sv]
`default_nettype none
module tb_request_deque_with_drop_unit;

	localparam int DEPTH = 16;
	localparam int WATCHDOG_LIMIT = 20000;

	typedef struct packed {
		logic [15:0] fd;
		logic [31:0] tag;
		logic [1:0]  st;
		logic [4:0]  cnt;
		logic        emp;
		logic        lst;
	} result_t;

	typedef struct {
		logic [2:0]  rt;
		logic [15:0] fd;
		logic [31:0] tag;
		bit          typed;
		result_t     res;
	} dir_row_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [2:0]  req_type;
	logic [15:0] request_fd;
	logic [31:0] request_tag;
	logic        out_valid;
	logic        out_stall;
	logic [15:0] result_fd;
	logic [31:0] result_tag;
	logic [1:0]  status;
	logic [4:0]  entry_count;
	logic        queue_empty;
	logic        last;

	// predictor state
	logic [15:0] q_fd[DEPTH];
	logic [31:0] q_tag[DEPTH];
	int          q_held;
	logic [15:0] q_lfsr;

	result_t     expected_q[$];
	dir_row_t    dir_rows[$];
	int          mismatches = 0;
	int          results_seen = 0;
	int          idle_cycles = 0;
	int          send_idle_pct;
	int          recv_stall_pct;
	bit          hold_recv;
	bit          stim_done;
	logic [15:0] next_fd;

	request_deque_with_drop_unit #(.DEPTH(DEPTH)) uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.req_type(req_type), .request_fd(request_fd), .request_tag(request_tag),
		.out_valid(out_valid), .out_stall(out_stall),
		.result_fd(result_fd), .result_tag(result_tag), .status(status),
		.entry_count(entry_count), .queue_empty(queue_empty), .last(last)
	);

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	function automatic result_t mk_result(logic [15:0] f, logic [31:0] t, logic [1:0] s,
			int cnt, bit lst);
		result_t r;
		r.fd = f;
		r.tag = t;
		r.st = s;
		r.cnt = cnt[4:0];
		r.emp = (cnt == 0);
		r.lst = lst;
		return r;
	endfunction

	function automatic void remove_slot(int idx);
		for (int i = idx; i + 1 < q_held; i++) begin
			q_fd[i] = q_fd[i + 1];
			q_tag[i] = q_tag[i + 1];
		end
		q_held--;
	endfunction

	// expected results of one request beat; updates the queue model
	function automatic void predict_request(logic [2:0] rt, logic [15:0] f, logic [31:0] t);
		logic [15:0] snap_fd[DEPTH];
		logic [31:0] snap_tag[DEPTH];
		bit          taken[DEPTH];
		int          n, goal, done, idx, w;
		bit          hit;
		n = 0;
		hit = 0;
		case (rt)
			rdwd_pkg::REQ_PUSH_TAIL: begin
				if (q_held >= DEPTH) begin
					expected_q.push_back(mk_result(0, 0, rdwd_pkg::ST_FULL, q_held, 1));
				end else begin
					q_fd[q_held] = f;
					q_tag[q_held] = t;
					q_held++;
					expected_q.push_back(mk_result(0, 0, rdwd_pkg::ST_DONE, q_held, 1));
				end
			end
			rdwd_pkg::REQ_POP_HEAD, rdwd_pkg::REQ_POP_TAIL: begin
				if (q_held == 0) begin
					expected_q.push_back(mk_result(0, 0, rdwd_pkg::ST_EMPTY, 0, 1));
				end else begin
					idx = (rt == rdwd_pkg::REQ_POP_HEAD) ? 0 : q_held - 1;
					snap_fd[0] = q_fd[idx];
					snap_tag[0] = q_tag[idx];
					remove_slot(idx);
					expected_q.push_back(mk_result(snap_fd[0], snap_tag[0],
						rdwd_pkg::ST_DONE, q_held, 1));
				end
			end
			rdwd_pkg::REQ_DELETE: begin
				for (int i = 0; i < q_held && !hit; i++) begin
					if (q_fd[i] == f) begin
						snap_tag[0] = q_tag[i];
						remove_slot(i);
						expected_q.push_back(mk_result(f, snap_tag[0],
							rdwd_pkg::ST_DONE, q_held, 1));
						hit = 1;
					end
				end
				if (!hit)
					expected_q.push_back(mk_result(0, 0, rdwd_pkg::ST_EMPTY, q_held, 1));
			end
			rdwd_pkg::REQ_DROP_HALF: begin
				n = q_held;
				if (n == 0) begin
					expected_q.push_back(mk_result(0, 0, rdwd_pkg::ST_EMPTY, 0, 1));
				end else begin
					for (int i = 0; i < DEPTH; i++) begin
						snap_fd[i] = q_fd[i];
						snap_tag[i] = q_tag[i];
						taken[i] = 0;
					end
					goal = (n + 1) / 2;
					done = 0;
					while (done < goal) begin
						q_lfsr = q_lfsr[0] ? ((q_lfsr >> 1) ^ rdwd_pkg::LFSR_TAPS)
						                   : (q_lfsr >> 1);
						idx = int'(q_lfsr) % n;
						if (!taken[idx]) begin
							taken[idx] = 1;
							done++;
							expected_q.push_back(mk_result(snap_fd[idx], snap_tag[idx],
								rdwd_pkg::ST_DONE, n - done, done == goal));
						end
					end
					w = 0;
					for (int i = 0; i < n; i++) begin
						if (!taken[i]) begin
							q_fd[w] = snap_fd[i];
							q_tag[w] = snap_tag[i];
							w++;
						end
					end
					q_held = w;
				end
			end
			default: expected_q.push_back(mk_result(0, 0, rdwd_pkg::ST_EMPTY, q_held, 1));
		endcase
	endfunction

	// drive one request beat and wait for it to be taken
	task automatic send_request(logic [2:0] rt, logic [15:0] f, logic [31:0] t);
		while (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1;
		req_type <= rt;
		request_fd <= f;
		request_tag <= t;
		predict_request(rt, f, t);
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		// block stalls its input after taking a beat
		in_valid <= 0;
		@(posedge clk);
	endtask

	task automatic wait_drained();
		while (expected_q.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	function automatic dir_row_t row(logic [2:0] rt, logic [15:0] f, logic [31:0] t, bit typed,
			result_t r);
		dir_row_t d;
		d.rt = rt;
		d.fd = f;
		d.tag = t;
		d.typed = typed;
		d.res = r;
		return d;
	endfunction

	// random request: mostly pushes and removals of held descriptors
	task automatic random_request();
		int          pick;
		logic [15:0] f;
		pick = $urandom_range(99, 0);
		f = 16'($urandom);
		if (pick < 45) begin
			next_fd = next_fd + 16'd1 + 16'($urandom_range(300, 0));
			send_request(rdwd_pkg::REQ_PUSH_TAIL,
				($urandom_range(9, 0) == 0) ? 16'($urandom) : next_fd, $urandom);
		end else if (pick < 57) begin
			send_request(rdwd_pkg::REQ_POP_HEAD, f, $urandom);
		end else if (pick < 69) begin
			send_request(rdwd_pkg::REQ_POP_TAIL, f, $urandom);
		end else if (pick < 84) begin
			if (q_held > 0 && $urandom_range(3, 0) != 0)
				f = q_fd[$urandom_range(q_held - 1, 0)];
			send_request(rdwd_pkg::REQ_DELETE, f, $urandom);
		end else if (pick < 96) begin
			send_request(rdwd_pkg::REQ_DROP_HALF, f, $urandom);
		end else begin
			send_request(3'($urandom_range(7, 5)), f, $urandom);
		end
	endtask

	// receiver: stalls at random, and holds off entirely on request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			out_stall <= hold_recv ||
				(recv_stall_pct > 0 && $urandom_range(99, 0) < recv_stall_pct);
		end
	end

	// result beat check
	always @(posedge clk) begin
		result_t got, want;
		if (arst_n && out_valid && !out_stall) begin
			got = {result_fd, result_tag, status, entry_count, queue_empty, last};
			results_seen++;
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result beat fd=%h tag=%h st=%0d cnt=%0d",
						result_fd, result_tag, status, entry_count);
			end else begin
				want = expected_q.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("mismatch: exp fd=%h tag=%h st=%0d cnt=%0d emp=%0b last=%0b",
							want.fd, want.tag, want.st, want.cnt, want.emp, want.lst);
						$display("          got fd=%h tag=%h st=%0d cnt=%0d emp=%0b last=%0b",
							got.fd, got.tag, got.st, got.cnt, got.emp, got.lst);
					end
				end
			end
		end
	end

	// watchdog on accepted beats
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
				|| hold_recv || stim_done) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
				$display("tb_request_deque_with_drop_unit failed");
				$finish;
			end
		end
	end

	initial begin
		int n_random;
		arst_n = 0;
		in_valid = 0;
		req_type = rdwd_pkg::REQ_PUSH_TAIL;
		request_fd = 0;
		request_tag = 0;
		hold_recv = 0;
		stim_done = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		q_held = 0;
		q_lfsr = rdwd_pkg::LFSR_SEED;
		next_fd = 16'd100;
		for (int i = 0; i < DEPTH; i++) begin
			q_fd[i] = 0;
			q_tag[i] = 0;
		end
		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed rows; typed results where obvious, the rest predicted
		dir_rows.push_back(row(rdwd_pkg::REQ_POP_HEAD, 16'h0000, 32'h0, 1,
			mk_result(0, 0, rdwd_pkg::ST_EMPTY, 0, 1)));
		dir_rows.push_back(row(rdwd_pkg::REQ_POP_TAIL, 16'hFFFF, 32'hFFFFFFFF, 1,
			mk_result(0, 0, rdwd_pkg::ST_EMPTY, 0, 1)));
		dir_rows.push_back(row(rdwd_pkg::REQ_DELETE, 16'h1234, 32'h0, 1,
			mk_result(0, 0, rdwd_pkg::ST_EMPTY, 0, 1)));
		dir_rows.push_back(row(rdwd_pkg::REQ_DROP_HALF, 16'h0, 32'h0, 1,
			mk_result(0, 0, rdwd_pkg::ST_EMPTY, 0, 1)));
		dir_rows.push_back(row(3'd7, 16'hFFFF, 32'hFFFFFFFF, 1,
			mk_result(0, 0, rdwd_pkg::ST_EMPTY, 0, 1)));
		dir_rows.push_back(row(rdwd_pkg::REQ_PUSH_TAIL, 16'hFFFF, 32'hFFFFFFFF, 1,
			mk_result(0, 0, rdwd_pkg::ST_DONE, 1, 1)));
		dir_rows.push_back(row(rdwd_pkg::REQ_PUSH_TAIL, 16'h0000, 32'h00000000, 1,
			mk_result(0, 0, rdwd_pkg::ST_DONE, 2, 1)));
		dir_rows.push_back(row(rdwd_pkg::REQ_POP_TAIL, 16'h0, 32'h0, 1,
			mk_result(16'h0000, 32'h0, rdwd_pkg::ST_DONE, 1, 1)));
		dir_rows.push_back(row(rdwd_pkg::REQ_POP_HEAD, 16'h0, 32'h0, 1,
			mk_result(16'hFFFF, 32'hFFFFFFFF, rdwd_pkg::ST_DONE, 0, 1)));
		for (int i = 0; i < DEPTH; i++)
			dir_rows.push_back(row(rdwd_pkg::REQ_PUSH_TAIL, (i == 5) ? 16'h0007 : 16'(i + 1),
				32'hA5A50000 | i, 0, mk_result(0, 0, rdwd_pkg::ST_DONE, 0, 0)));
		foreach (dir_rows[i]) begin
			send_request(dir_rows[i].rt, dir_rows[i].fd, dir_rows[i].tag);
			if (dir_rows[i].typed)
				expected_q[expected_q.size() - 1] = dir_rows[i].res;
		end
		// full queue: refusal, duplicate delete, an unknown code, then two drops
		send_request(rdwd_pkg::REQ_PUSH_TAIL, 16'hBEEF, 32'h1);
		send_request(rdwd_pkg::REQ_DELETE, 16'h0007, 32'h0);
		send_request(3'd5, 16'h0, 32'h0);
		send_request(rdwd_pkg::REQ_DROP_HALF, 16'h0, 32'h0);
		send_request(rdwd_pkg::REQ_DROP_HALF, 16'h0, 32'h0);
		wait_drained();

		// receiver holds off while the sender keeps sending requests
		hold_recv = 1;
		fork
			begin
				repeat (300) @(posedge clk);
				hold_recv = 0;
			end
			begin
				repeat (6) random_request();
			end
		join
		wait_drained();

		// random phases: none, sender idle, receiver stall, both
		n_random = 0;
		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 3) ? 11 : 82) : 0;
			recv_stall_pct = (ph == 2 || ph == 3) ? ((ph == 3) ? 11 : 82) : 0;
			for (int i = 0; i < 44; i++) begin
				random_request();
				n_random++;
			end
			wait_drained();
		end
		stim_done = 1;
		$display("covered %0d directed, 6 back-pressure and %0d random requests",
			dir_rows.size() + 5, n_random);
		$display("across idle and stall phases, %0d result beats checked", results_seen);
		if (mismatches == 0 && expected_q.size() == 0) begin
			$display("tb_request_deque_with_drop_unit passed");
		end else begin
			$display("%0d mismatches, %0d results outstanding", mismatches, expected_q.size());
			$display("tb_request_deque_with_drop_unit failed");
		end
		$finish;
	end
endmodule
`default_nettype wire

[sim.f]
rtl/rdwd_pkg.sv
rtl/rdwd_ram.sv
rtl/request_deque_with_drop_unit.sv
sim/tb_request_deque_with_drop_unit.sv
